### design/ubef_pkg.sv
// shared payload types and descriptor constants for the bulk endpoint finder
package ubef_pkg;

	typedef struct packed {
		logic [7:0] desc_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [7:0] interface_number;
		logic [7:0] out_endpoint;
		logic [7:0] in_endpoint;
	} out_item_t;

	localparam logic [7:0] PREF_CLASS_RESET = 8'd8;

	localparam logic [7:0] DESC_TYPE_INTERFACE = 8'd4;
	localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'd5;
	localparam logic [7:0] MIN_DESC_LEN        = 8'd2;
	localparam logic [7:0] MIN_IF_LEN          = 8'd9;
	localparam logic [7:0] MIN_EP_LEN          = 8'd7;

	localparam logic [7:0] OFS_LENGTH      = 8'd0;
	localparam logic [7:0] OFS_TYPE        = 8'd1;
	localparam logic [7:0] OFS_FIELD_TWO   = 8'd2;
	localparam logic [7:0] OFS_FIELD_THREE = 8'd3;
	localparam logic [7:0] OFS_FIELD_FIVE  = 8'd5;

	localparam logic [1:0] XFER_TYPE_BULK = 2'd2;
	localparam int         EP_DIR_BIT     = 7;

endpackage

### design/ubef_parser.sv
// descriptor walker: parse state registers and per-byte next-state logic
module ubef_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  ubef_pkg::in_item_t item,
	input  logic [7:0]         pref_class,
	output ubef_pkg::out_item_t result
);

	typedef struct packed {
		logic [7:0] byte_offset;
		logic [7:0] desc_length;
		logic [7:0] desc_type;
		logic [7:0] field_two;
		logic [7:0] field_three;
		logic [7:0] field_five;
		logic       halted;
		logic       have_interface;
		logic [7:0] current_interface;
		logic [7:0] current_class;
		logic       pref_found;
		logic [7:0] pref_interface;
		logic [7:0] pref_out;
		logic [7:0] pref_in;
		logic       fallback_valid;
		logic [7:0] fallback_interface;
		logic [7:0] fallback_out;
		logic [7:0] fallback_in;
	} parse_state_t;

	parse_state_t st_q;
	parse_state_t nxt;

	always_comb begin
		logic       is_out;
		logic [7:0] b;
		b      = item.desc_byte;
		nxt    = st_q;
		is_out = 1'b0;
		if (!st_q.halted) begin
			if (st_q.byte_offset == ubef_pkg::OFS_LENGTH) begin
				nxt.desc_length = b;
				if (b < ubef_pkg::MIN_DESC_LEN) begin
					nxt.halted = 1'b1;
				end else begin
					nxt.byte_offset = ubef_pkg::OFS_TYPE;
				end
			end else begin
				case (st_q.byte_offset)
					ubef_pkg::OFS_TYPE:        nxt.desc_type   = b;
					ubef_pkg::OFS_FIELD_TWO:   nxt.field_two   = b;
					ubef_pkg::OFS_FIELD_THREE: nxt.field_three = b;
					ubef_pkg::OFS_FIELD_FIVE:  nxt.field_five  = b;
					default: ;
				endcase
				if ({1'b0, st_q.byte_offset} + 9'd1 == {1'b0, st_q.desc_length}) begin
					// descriptor complete: act on it
					nxt.byte_offset = ubef_pkg::OFS_LENGTH;
					is_out = !nxt.field_two[ubef_pkg::EP_DIR_BIT];
					if (nxt.desc_type == ubef_pkg::DESC_TYPE_INTERFACE &&
					    st_q.desc_length >= ubef_pkg::MIN_IF_LEN) begin
						nxt.have_interface    = 1'b1;
						nxt.current_interface = nxt.field_two;
						nxt.current_class     = nxt.field_five;
					end else if (nxt.desc_type == ubef_pkg::DESC_TYPE_ENDPOINT &&
					             st_q.desc_length >= ubef_pkg::MIN_EP_LEN &&
					             st_q.have_interface &&
					             nxt.field_three[1:0] == ubef_pkg::XFER_TYPE_BULK) begin
						if (st_q.current_class == pref_class) begin
							if (is_out && !st_q.pref_found) begin
								nxt.pref_interface = st_q.current_interface;
								nxt.pref_out       = nxt.field_two;
								nxt.pref_found     = 1'b1;
							end else if (!is_out && st_q.pref_found &&
							             st_q.pref_interface == st_q.current_interface &&
							             st_q.pref_in == 8'd0) begin
								nxt.pref_in = nxt.field_two;
							end
						end
						if (!st_q.fallback_valid && is_out) begin
							nxt.fallback_interface = st_q.current_interface;
							nxt.fallback_out       = nxt.field_two;
							nxt.fallback_valid     = 1'b1;
						end else if (!is_out && st_q.fallback_valid &&
						             st_q.fallback_interface == st_q.current_interface &&
						             st_q.fallback_in == 8'd0) begin
							nxt.fallback_in = nxt.field_two;
						end
					end
				end else begin
					nxt.byte_offset = st_q.byte_offset + 8'd1;
				end
			end
		end
	end

	// result reflects the state after this byte has been taken
	always_comb begin
		if (nxt.pref_found) begin
			result.found            = 1'b1;
			result.interface_number = nxt.pref_interface;
			result.out_endpoint     = nxt.pref_out;
			result.in_endpoint      = nxt.pref_in;
		end else if (nxt.fallback_valid) begin
			result.found            = 1'b1;
			result.interface_number = nxt.fallback_interface;
			result.out_endpoint     = nxt.fallback_out;
			result.in_endpoint      = nxt.fallback_in;
		end else begin
			result = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			if (item.last_byte) begin
				st_q <= '0;
			end else begin
				st_q <= nxt;
			end
		end
	end

endmodule

### design/usb_bulk_endpoint_finder.sv
// top level: input register, config register, parser and result register
// the result register loads when the last item of a set leaves the input register
// throughput: one item per cycle while no last item waits; the parser takes each
//   item from the input register and the result register drains independently
// an item flagged last is held in the input register only while the result
//   register is full and not being taken
// reset clears all parse state and sets preferred_class to 8 (mass storage)
module usb_bulk_endpoint_finder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ubef_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ubef_pkg::out_item_t out_data,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data
);

	// config register
	logic [7:0] pref_class_q;

	// input register
	logic               valid_s1;
	ubef_pkg::in_item_t item_s1;

	// result register
	logic                out_valid_q;
	ubef_pkg::out_item_t out_data_q;

	logic                out_free;
	logic                fire;
	ubef_pkg::out_item_t result;

	// result slot can take a new item if empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// a non-last item produces no result so it never waits on the output side
	assign fire     = valid_s1 && (!item_s1.last_byte || out_free);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_class_q <= ubef_pkg::PREF_CLASS_RESET;
		end else if (cfg_wr_en) begin
			pref_class_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	ubef_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.pref_class (pref_class_q),
		.result     (result)
	);

	// result register loads when the last item of a set is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s1.last_byte) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// empty input register always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but not ready");

	// processing a last item always yields a result next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.last_byte) |=> out_valid_q)
		else $error("last item processed without result");

	// a last item may not overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s1 && item_s1.last_byte) |-> !fire)
		else $error("pending result overwritten");

	// nothing found means all fields zero
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.found) |->
		(out_data_q.interface_number == 8'd0 && out_data_q.out_endpoint == 8'd0 &&
		 out_data_q.in_endpoint == 8'd0))
		else $error("non-zero fields without a found endpoint");

	// a chosen out endpoint has its direction bit clear
	a_out_direction: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.found) |->
		!out_data_q.out_endpoint[ubef_pkg::EP_DIR_BIT])
		else $error("chosen out endpoint has in direction");

endmodule

### sim/usb_bulk_endpoint_finder_test.sv
// testbench for the bulk endpoint finder: predicted endpoint choices checked against the block
`timescale 1ns / 1ps

module usb_bulk_endpoint_finder_test;

	// cycles with no accepted item on either side before the run is given up
	localparam int WATCHDOG_LIMIT = 4000;
	// long receiver hold-off so the result register fills and the input stalls
	localparam int HOLD_CYCLES    = 300;
	// quiet cycles before a register write, after the last result has been checked
	localparam int SETTLE_CYCLES  = 4;
	// input items per random phase
	localparam int PHASE_ITEMS    = 305;
	localparam int NUM_PHASES     = 6;

	// tracks the parse of each descriptor set and holds the endpoint choices
	// that the block must report, oldest first
	class endpoint_choice_checker;
		ubef_pkg::out_item_t expected_choices[$];
		int unsigned mismatches;
		logic [7:0]  pref_class;
		// position in the descriptor under way and its saved bytes
		logic [7:0]  ofs, len, dtype, f_two, f_three, f_five;
		bit          halted, have_if, pref_ok, fb_ok;
		logic [7:0]  cur_if, if_class;
		logic [7:0]  pref_if, pref_out, pref_in;
		logic [7:0]  fb_if, fb_out, fb_in;

		function new();
			pref_class = ubef_pkg::PREF_CLASS_RESET;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			ofs = '0; len = '0; dtype = '0;
			f_two = '0; f_three = '0; f_five = '0;
			halted = 1'b0; have_if = 1'b0; pref_ok = 1'b0; fb_ok = 1'b0;
			cur_if = '0; if_class = '0;
			pref_if = '0; pref_out = '0; pref_in = '0;
			fb_if = '0; fb_out = '0; fb_in = '0;
		endfunction

		function void note_item(ubef_pkg::in_item_t it);
			bit                  is_out;
			ubef_pkg::out_item_t choice;
			if (!halted) begin
				if (ofs == ubef_pkg::OFS_LENGTH) begin
					len = it.desc_byte;
					// a length below two stops the walk for the rest of the set
					if (it.desc_byte < ubef_pkg::MIN_DESC_LEN)
						halted = 1'b1;
					else
						ofs = ubef_pkg::OFS_TYPE;
				end else begin
					case (ofs)
						ubef_pkg::OFS_TYPE:        dtype   = it.desc_byte;
						ubef_pkg::OFS_FIELD_TWO:   f_two   = it.desc_byte;
						ubef_pkg::OFS_FIELD_THREE: f_three = it.desc_byte;
						ubef_pkg::OFS_FIELD_FIVE:  f_five  = it.desc_byte;
						default: ;
					endcase
					if (int'(ofs) + 1 == int'(len)) begin
						// descriptor complete, act on it
						ofs = ubef_pkg::OFS_LENGTH;
						if (dtype == ubef_pkg::DESC_TYPE_INTERFACE &&
								len >= ubef_pkg::MIN_IF_LEN) begin
							have_if  = 1'b1;
							cur_if   = f_two;
							if_class = f_five;
						end else if (dtype == ubef_pkg::DESC_TYPE_ENDPOINT &&
								len >= ubef_pkg::MIN_EP_LEN && have_if &&
								f_three[1:0] == ubef_pkg::XFER_TYPE_BULK) begin
							is_out = !f_two[ubef_pkg::EP_DIR_BIT];
							if (if_class == pref_class) begin
								if (is_out && !pref_ok) begin
									pref_if  = cur_if;
									pref_out = f_two;
									pref_ok  = 1'b1;
								end else if (!is_out && pref_ok && pref_if == cur_if &&
										pref_in == 8'h00) begin
									pref_in = f_two;
								end
							end
							if (!fb_ok && is_out) begin
								fb_if  = cur_if;
								fb_out = f_two;
								fb_ok  = 1'b1;
							end else if (!is_out && fb_ok && fb_if == cur_if &&
									fb_in == 8'h00) begin
								fb_in = f_two;
							end
						end
					end else begin
						ofs++;
					end
				end
			end
			if (it.last_byte) begin
				if (pref_ok)
					choice = '{1'b1, pref_if, pref_out, pref_in};
				else if (fb_ok)
					choice = '{1'b1, fb_if, fb_out, fb_in};
				else
					choice = '0;
				expected_choices.push_back(choice);
				restart();
			end
		endfunction

		function void check_result(ubef_pkg::out_item_t got);
			ubef_pkg::out_item_t want;
			if (expected_choices.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0b if %h out %h in %h",
					$time, got.found, got.interface_number, got.out_endpoint,
					got.in_endpoint);
				mismatches++;
				return;
			end
			want = expected_choices.pop_front();
			if (got.found !== want.found) begin
				$display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
				mismatches++;
			end
			if (got.interface_number !== want.interface_number) begin
				$display("%0t: interface_number expected %h actual %h", $time,
					want.interface_number, got.interface_number);
				mismatches++;
			end
			if (got.out_endpoint !== want.out_endpoint) begin
				$display("%0t: out_endpoint expected %h actual %h", $time,
					want.out_endpoint, got.out_endpoint);
				mismatches++;
			end
			if (got.in_endpoint !== want.in_endpoint) begin
				$display("%0t: in_endpoint expected %h actual %h", $time,
					want.in_endpoint, got.in_endpoint);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	ubef_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	ubef_pkg::out_item_t out_data;
	logic                cfg_wr_en;
	logic [7:0]          cfg_wr_data;

	endpoint_choice_checker choices = new();

	// calm: no idling on either side; hold_out: ask the receiver for a long hold-off
	bit          calm = 1'b0;
	bit          hold_out = 1'b0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;

	usb_bulk_endpoint_finder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// push one descriptor set, the final byte flagged last; sender gaps come in
	// bursts, with the odds drawn per set so some sets go through back to back
	task automatic send_set(input logic [7:0] set_bytes[$]);
		int unsigned gap_odds;
		gap_odds = calm ? 0 : $urandom_range(0, 4);
		for (int k = 0; k < set_bytes.size(); k++) begin
			if ($urandom_range(0, 15) < gap_odds) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_data  <= '{desc_byte: set_bytes[k], last_byte: (k == set_bytes.size() - 1)};
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			items_sent++;
		end
	endtask

	// preferred_class is only written once the block has gone quiet
	task automatic write_class(input logic [7:0] cls);
		in_valid <= 1'b0;
		// wait on the clock first so the last accepted item is already in the predictor
		@(posedge clk);
		while (choices.expected_choices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cls;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		choices.pref_class = cls;
	endtask

	// accepted items feed the predictor, accepted results are checked;
	// the watchdog ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				choices.note_item(in_data);
			if (out_valid && out_ready)
				choices.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// receiver: random ready bursts, one long hold-off on request
	initial begin : result_side
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_out) begin
				hold_out = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [7:0]  set_bytes[$];
		logic [7:0]  plan[NUM_PHASES];
		logic [7:0]  dtype, ifnum, cls, addr, attr, b;
		int unsigned mode, kind, len, phase_start;

		in_valid    <= 1'b0;
		in_data     <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		arst_n      <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets, preferred_class still at its reset value
		// zero length halts at once, nothing found
		set_bytes = '{8'h00};
		send_set(set_bytes);
		// a 255-byte descriptor cut short by the end of the set
		set_bytes = '{8'hFF};
		send_set(set_bytes);
		// bulk endpoint with no interface ahead of it is ignored
		set_bytes = '{8'h07, ubef_pkg::DESC_TYPE_ENDPOINT, 8'h01, 8'h02, 8'h00, 8'h00,
			8'h00};
		send_set(set_bytes);
		// mass storage interface 0xff with a bulk OUT endpoint, byte extremes
		set_bytes = '{8'h09, ubef_pkg::DESC_TYPE_INTERFACE, 8'hFF, 8'h00, 8'h02,
			ubef_pkg::PREF_CLASS_RESET, 8'hFF, 8'h00, 8'hFF,
			8'h07, ubef_pkg::DESC_TYPE_ENDPOINT, 8'h7F, 8'hFE, 8'hFF, 8'hFF, 8'h00};
		send_set(set_bytes);

		// random phases, each under its own preferred class, extremes included
		plan = '{8'h00, 8'hFF, 8'h03, 8'($urandom), ubef_pkg::PREF_CLASS_RESET,
			8'($urandom)};
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_class(plan[p]);
			// last phase runs with no idling at all
			if (p == NUM_PHASES - 1)
				calm = 1'b1;
			// long receiver hold-off while sets keep coming
			if (p == 2)
				hold_out = 1'b1;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				set_bytes.delete();
				// mode 0: raw noise, mode 1: broken set, otherwise well formed
				mode = $urandom_range(0, 9);
				if (mode == 0) begin
					repeat ($urandom_range(1, 24)) set_bytes.push_back(8'($urandom));
				end else begin
					repeat ($urandom_range(1, 6)) begin
						kind  = $urandom_range(0, 9);
						ifnum = ($urandom_range(0, 5) == 0) ? 8'($urandom)
							: 8'($urandom_range(0, 3));
						case ($urandom_range(0, 3))
							0, 1:    cls = choices.pref_class;
							2:       cls = 8'($urandom);
							default: cls = 8'(choices.pref_class + 8'd1);
						endcase
						addr = ($urandom_range(0, 7) == 0) ? 8'($urandom)
							: {1'($urandom), 3'b000, 4'($urandom_range(0, 15))};
						attr = ($urandom_range(0, 4) == 0) ? 8'($urandom)
							: {6'($urandom), ubef_pkg::XFER_TYPE_BULK};
						if (kind <= 2) begin
							// interface, now and then with an odd length
							dtype = ubef_pkg::DESC_TYPE_INTERFACE;
							len   = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12)
								: int'(ubef_pkg::MIN_IF_LEN);
						end else if (kind <= 7) begin
							// endpoint, now and then short or padded
							dtype = ubef_pkg::DESC_TYPE_ENDPOINT;
							len   = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 10)
								: int'(ubef_pkg::MIN_EP_LEN);
						end else if (kind == 8) begin
							dtype = 8'($urandom);
							len   = $urandom_range(2, 12);
						end else begin
							// broken sets get a halting length, others a long skip
							dtype = 8'($urandom);
							len   = (mode == 1) ? $urandom_range(0, 1) : $urandom_range(13, 40);
						end
						set_bytes.push_back(8'(len));
						for (int j = 1; j < len; j++) begin
							b = 8'($urandom);
							if (j == 1)
								b = dtype;
							else if (kind <= 2 && j == 2)
								b = ifnum;
							else if (kind <= 2 && j == 5)
								b = cls;
							else if (kind >= 3 && kind <= 7 && j == 2)
								b = addr;
							else if (kind >= 3 && kind <= 7 && j == 3)
								b = attr;
							set_bytes.push_back(b);
						end
					end
					// broken sets are also cut short at a random point
					if (mode == 1 && set_bytes.size() > 1)
						set_bytes = set_bytes[0:$urandom_range(0, set_bytes.size() - 2)];
				end
				send_set(set_bytes);
			end
		end

		// drain, then keep the clock running to catch stray results
		in_valid <= 1'b0;
		@(posedge clk);
		while (choices.expected_choices.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (choices.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
design/ubef_pkg.sv
design/ubef_parser.sv
design/usb_bulk_endpoint_finder.sv
sim/usb_bulk_endpoint_finder_test.sv
